/* rtl/core/wedt_pkg.sv */
// Shared constants, types and a helper function for the wheel encoder delta tracker.
`timescale 1ns / 1ps
`default_nettype none

package wedt_pkg;

  // Moving window depth (number of changes averaged by the consumer).
  localparam int WINDOW_DEPTH = 5;

  localparam int RAW_W      = 16;
  localparam int DELTA_W    = 17;
  localparam int WSUM_W     = 20;
  localparam int FILL_OUT_W = 3;
  localparam int TOTAL_W    = 32;
  localparam int MOD_W      = 17;
  localparam int DB_W       = 16;
  localparam int TENTH_W    = 14;
  localparam int DIFF_W     = 19;

  localparam int SUM_W  = DELTA_W + $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int EXT_W  = ((SUM_W > WSUM_W) ? SUM_W : WSUM_W) + 1;

  // Divide by ten as a multiply by a reciprocal; exact for every 17-bit modulus.
  localparam int RECIP       = 52429;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = MOD_W + RECIP_W;

  localparam logic [MOD_W-1:0]   MOD_RESET   = 17'h10000;
  localparam logic [TENTH_W-1:0] TENTH_RESET = 14'd6553;
  localparam logic [DB_W-1:0]    DB_RESET    = 16'd0;

  localparam int FILL_OUT_MAX = 7;

  localparam logic REG_WRAP_MODULUS = 1'b0;
  localparam logic REG_DEADBAND     = 1'b1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic signed [DELTA_W:0] DELTA_MAX = 18'sd65535;
  localparam logic signed [DELTA_W:0] DELTA_MIN = -18'sd65536;

  localparam logic signed [EXT_W-1:0] WSUM_MAX = EXT_W'((2 ** (WSUM_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] WSUM_MIN = -EXT_W'(2 ** (WSUM_W - 1));

  typedef struct packed {
    logic [MOD_W-1:0]   modulus;
    logic [TENTH_W-1:0] tenth;
    logic [DB_W-1:0]    deadband;
  } cfg_t;

  typedef struct packed {
    logic step;
    logic clr;
    logic seen_first;
  } ctl_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic signed [WSUM_W-1:0]  wsum;
    logic [TOTAL_W-1:0]        total;
  } lane_res_t;

  // Clamp the exact window sum into the reported signed range.
  function automatic logic signed [WSUM_W-1:0] sat_wsum(input logic signed [SUM_W-1:0] s);
    logic signed [EXT_W-1:0] e;
    logic signed [WSUM_W-1:0] r;
    e = {{(EXT_W - SUM_W){s[SUM_W-1]}}, s};
    if (e > WSUM_MAX) begin
      r = WSUM_MAX[WSUM_W-1:0];
    end else if (e < WSUM_MIN) begin
      r = WSUM_MIN[WSUM_W-1:0];
    end else begin
      r = e[WSUM_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/wheel_encoder_delta_tracker.sv */
// A result word is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while out_ready is high; the single output register frees as it is taken.
// The change, total and window sum for a word are settled in the accept cycle, so
// each word sees the state left by the one before it without a bubble.
// Reset (synchronous, active high) restores modulus 65536, deadband 0, empty
// windows, zero totals and no previous reading; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module wheel_encoder_delta_tracker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                operation,
  input  wire logic [wedt_pkg::RAW_W-1:0]          left_raw,
  input  wire logic [wedt_pkg::RAW_W-1:0]          right_raw,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [wedt_pkg::DELTA_W-1:0]      left_delta,
  output logic signed [wedt_pkg::DELTA_W-1:0]      right_delta,
  output logic signed [wedt_pkg::WSUM_W-1:0]       left_window_sum,
  output logic signed [wedt_pkg::WSUM_W-1:0]       right_window_sum,
  output logic [wedt_pkg::FILL_OUT_W-1:0]          window_fill,
  output logic [wedt_pkg::TOTAL_W-1:0]             left_total,
  output logic [wedt_pkg::TOTAL_W-1:0]             right_total,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic                                cfg_index,
  input  wire logic [wedt_pkg::MOD_W-1:0]          cfg_data
);

  wedt_pkg::cfg_t      cfg;
  wedt_pkg::ctl_t      ctl;
  wedt_pkg::lane_res_t left_res;
  wedt_pkg::lane_res_t right_res;

  wedt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wedt_lane u_left (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .ctl (ctl),
    .raw (left_raw),
    .res (left_res)
  );

  wedt_lane u_right (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .ctl (ctl),
    .raw (right_raw),
    .res (right_res)
  );

  wedt_merge u_merge (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .ctl              (ctl),
    .left_res         (left_res),
    .right_res        (right_res),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .left_delta       (left_delta),
    .right_delta      (right_delta),
    .left_window_sum  (left_window_sum),
    .right_window_sum (right_window_sum),
    .window_fill      (window_fill),
    .left_total       (left_total),
    .right_total      (right_total)
  );

endmodule

`default_nettype wire

/* rtl/core/wedt_cfg.sv */
// Configuration registers: wrap modulus with its precomputed tenth, and the deadband.
`timescale 1ns / 1ps
`default_nettype none

module wedt_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [wedt_pkg::MOD_W-1:0]    cfg_data,
  output wedt_pkg::cfg_t                     cfg
);

  logic [wedt_pkg::PROD_W-1:0]  prod;
  logic [wedt_pkg::TENTH_W-1:0] tenth_next;
  logic                         wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // The tenth is taken once per modulus write so the item path only compares.
  always_comb begin
    prod       = wedt_pkg::PROD_W'(cfg_data) * wedt_pkg::PROD_W'(wedt_pkg::RECIP);
    tenth_next = prod[wedt_pkg::RECIP_SHIFT +: wedt_pkg::TENTH_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus  <= wedt_pkg::MOD_RESET;
      cfg.tenth    <= wedt_pkg::TENTH_RESET;
      cfg.deadband <= wedt_pkg::DB_RESET;
    end else if (wr) begin
      case (cfg_index)
        wedt_pkg::REG_WRAP_MODULUS: begin
          cfg.modulus <= cfg_data;
          cfg.tenth   <= tenth_next;
        end
        wedt_pkg::REG_DEADBAND: begin
          cfg.deadband <= cfg_data[wedt_pkg::DB_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wedt_lane.sv */
// One wheel lane: wrap-corrected change, deadband, saturating total and moving window.
`timescale 1ns / 1ps
`default_nettype none

module wedt_lane (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire wedt_pkg::cfg_t                cfg,
  input  wire wedt_pkg::ctl_t                ctl,
  input  wire logic [wedt_pkg::RAW_W-1:0]    raw,
  output wedt_pkg::lane_res_t                res
);

  logic [wedt_pkg::RAW_W-1:0]          last;
  logic signed [wedt_pkg::DELTA_W-1:0] win [wedt_pkg::WINDOW_DEPTH];
  logic signed [wedt_pkg::SUM_W-1:0]   wsum;
  logic [wedt_pkg::TOTAL_W-1:0]        total;

  logic signed [wedt_pkg::DIFF_W-1:0]  diff;
  logic signed [wedt_pkg::DIFF_W-1:0]  modv;
  logic signed [wedt_pkg::DIFF_W-1:0]  tenv;
  logic signed [wedt_pkg::DIFF_W-1:0]  d1;
  logic signed [wedt_pkg::DIFF_W-1:0]  d2;
  logic signed [wedt_pkg::DELTA_W-1:0] dc;
  logic signed [wedt_pkg::DELTA_W:0]   neg;
  logic [wedt_pkg::DELTA_W-1:0]        mag;
  logic                                pass;
  logic signed [wedt_pkg::DELTA_W-1:0] dv;
  logic [wedt_pkg::TOTAL_W:0]          tot_add;
  logic [wedt_pkg::TOTAL_W-1:0]        tot_next;
  logic signed [wedt_pkg::SUM_W-1:0]   wsum_next;

  always_comb begin
    diff = $signed({3'b000, raw}) - $signed({3'b000, last});
    modv = $signed({2'b00, cfg.modulus});
    tenv = $signed({5'b00000, cfg.tenth});
    d1   = (diff > tenv) ? (diff - modv) : diff;
    d2   = (d1 < -tenv) ? (d1 + modv) : d1;

    if (!ctl.seen_first) begin
      dc = '0;
    end else if (d2 > wedt_pkg::DIFF_W'(wedt_pkg::DELTA_MAX)) begin
      dc = wedt_pkg::DELTA_MAX[wedt_pkg::DELTA_W-1:0];
    end else if (d2 < wedt_pkg::DIFF_W'(wedt_pkg::DELTA_MIN)) begin
      dc = wedt_pkg::DELTA_MIN[wedt_pkg::DELTA_W-1:0];
    end else begin
      dc = d2[wedt_pkg::DELTA_W-1:0];
    end

    // One extra bit so the most negative change has a representable magnitude.
    neg  = -$signed({dc[wedt_pkg::DELTA_W-1], dc});
    mag  = dc[wedt_pkg::DELTA_W-1] ? neg[wedt_pkg::DELTA_W-1:0] : dc;
    pass = mag > wedt_pkg::DELTA_W'(cfg.deadband);
    dv   = pass ? dc : '0;

    tot_add  = {1'b0, total} + (wedt_pkg::TOTAL_W + 1)'(mag);
    tot_next = tot_add[wedt_pkg::TOTAL_W] ? '1 : tot_add[wedt_pkg::TOTAL_W-1:0];

    // Running sum: the oldest slot is zero until the window has filled.
    wsum_next = wsum + wedt_pkg::SUM_W'(dv)
              - wedt_pkg::SUM_W'(win[wedt_pkg::WINDOW_DEPTH-1]);

    res.delta = ctl.clr ? '0 : dv;
    res.wsum  = ctl.clr ? '0 : wedt_pkg::sat_wsum(wsum_next);
    res.total = (pass && !ctl.clr) ? tot_next : total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last  <= '0;
      wsum  <= '0;
      total <= '0;
      for (int i = 0; i < wedt_pkg::WINDOW_DEPTH; i++) begin
        win[i] <= '0;
      end
    end else if (ctl.clr) begin
      wsum <= '0;
      for (int i = 0; i < wedt_pkg::WINDOW_DEPTH; i++) begin
        win[i] <= '0;
      end
    end else if (ctl.step) begin
      last  <= raw;
      wsum  <= wsum_next;
      if (pass) begin
        total <= tot_next;
      end
      win[0] <= dv;
      for (int i = 1; i < wedt_pkg::WINDOW_DEPTH; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  a_clr_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clr |=> (wsum == '0) && (win[0] == '0))
    else $error("window not emptied by clear");

  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    ctl.step |=> (total >= $past(total)))
    else $error("running total decreased");

  a_newest_entry: assert property (@(posedge clk) disable iff (rst)
    ctl.step |=> (win[0] == $past(res.delta)))
    else $error("newest window entry differs from reported change");

endmodule

`default_nettype wire

/* rtl/core/wedt_merge.sv */
// Handshake, shared fill count and first-sample flag, and the output register.
`timescale 1ns / 1ps
`default_nettype none

module wedt_merge (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                operation,
  output wedt_pkg::ctl_t                           ctl,
  input  wire wedt_pkg::lane_res_t                 left_res,
  input  wire wedt_pkg::lane_res_t                 right_res,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [wedt_pkg::DELTA_W-1:0]      left_delta,
  output logic signed [wedt_pkg::DELTA_W-1:0]      right_delta,
  output logic signed [wedt_pkg::WSUM_W-1:0]       left_window_sum,
  output logic signed [wedt_pkg::WSUM_W-1:0]       right_window_sum,
  output logic [wedt_pkg::FILL_OUT_W-1:0]          window_fill,
  output logic [wedt_pkg::TOTAL_W-1:0]             left_total,
  output logic [wedt_pkg::TOTAL_W-1:0]             right_total
);

  logic                          accept;
  logic                          seen_first;
  logic [wedt_pkg::FILL_W-1:0]   fill;
  logic [wedt_pkg::FILL_W-1:0]   fill_next;
  logic [wedt_pkg::FILL_OUT_W-1:0] fill_out;

  // The output register frees itself in the same cycle its word is taken.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctl.step       = accept && (operation == wedt_pkg::OP_SAMPLE);
    ctl.clr        = accept && (operation == wedt_pkg::OP_CLEAR);
    ctl.seen_first = seen_first;

    if (ctl.clr) begin
      fill_next = '0;
    end else if (ctl.step && (fill < wedt_pkg::FILL_W'(wedt_pkg::WINDOW_DEPTH))) begin
      fill_next = fill + 1'b1;
    end else begin
      fill_next = fill;
    end

    if (32'(fill_next) > 32'(wedt_pkg::FILL_OUT_MAX)) begin
      fill_out = wedt_pkg::FILL_OUT_W'(wedt_pkg::FILL_OUT_MAX);
    end else begin
      fill_out = wedt_pkg::FILL_OUT_W'(fill_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      seen_first <= 1'b0;
      fill       <= '0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.step) begin
        seen_first <= 1'b1;
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_delta       <= left_res.delta;
      right_delta      <= right_res.delta;
      left_window_sum  <= left_res.wsum;
      right_window_sum <= right_res.wsum;
      window_fill      <= fill_out;
      left_total       <= left_res.total;
      right_total      <= right_res.total;
    end
  end

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    ctl.clr |=> (window_fill == '0) && (left_window_sum == '0) && (right_window_sum == '0)
                && (left_delta == '0) && (right_delta == '0))
    else $error("clear result is not empty");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= wedt_pkg::FILL_W'(wedt_pkg::WINDOW_DEPTH))
    else $error("fill count beyond window depth");

endmodule

`default_nettype wire
